@@ hw/rtl/bmhpq_pkg.sv @@
// Package for the binary max-heap priority queue.
// Holds field widths, request and status codes, the word structs and defaults.
// Depends on nothing.
package bmhpq_pkg;

    localparam int FIELD_W   = 32;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = 9;

    localparam int DEF_CAPACITY  = 256;
    localparam int DEF_KEY_BITS  = 32;
    localparam int DEF_DATA_BITS = 32;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_CAPACITY_LIMIT = REG_IDX_W'(0);
    localparam logic [CNT_W-1:0]     LIMIT_RESET        = CNT_W'(256);

    localparam logic [KIND_W-1:0] KIND_INSERT  = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_EXTRACT = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_PEEK    = KIND_W'(2);

    localparam logic [STATUS_W-1:0] ST_OK        = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = STATUS_W'(2);

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] payload;
    } t_in_word;

    typedef struct packed {
        logic [FIELD_W-1:0]  top_key;
        logic [FIELD_W-1:0]  top_payload;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
    } t_out_word;

endpackage

@@ hw/rtl/bmhpq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used as the heap store; depends on nothing.
module bmhpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bmhpq_ctrl.sv @@
// Heap sequencer: sift-up and sift-down over the heap RAM with combinational key compares,
// plus the result register. Depends on bmhpq_pkg and bmhpq_ram.
module bmhpq_ctrl #(
    parameter int CAPACITY  = bmhpq_pkg::DEF_CAPACITY,
    parameter int KEY_BITS  = bmhpq_pkg::DEF_KEY_BITS,
    parameter int DATA_BITS = bmhpq_pkg::DEF_DATA_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bmhpq_pkg::t_in_word         i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output bmhpq_pkg::t_out_word        o_out_word,
    input  logic [bmhpq_pkg::CNT_W-1:0] i_limit
);
    import bmhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int EW = KEY_BITS + DATA_BITS;
    localparam int LW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP,
        S_UP_CMP,
        S_TOP_WAIT,
        S_LAST_WAIT,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [KIND_W-1:0]     r_kind;
    logic [STATUS_W-1:0]   r_status;
    logic [CNT_W-1:0]      r_cnt;
    logic [AW-1:0]         r_pos;
    logic [AW-1:0]         r_npos;
    logic [EW-1:0]         r_cur;
    logic [EW-1:0]         r_child;
    logic [EW-1:0]         r_top;
    logic                  r_take;
    logic                  r_rc_ok;
    logic                  r_out_valid;
    t_out_word             r_out;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [EW-1:0]         ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [EW-1:0]         ram_rdata;

    logic                  accept;
    logic                  out_free;
    logic [LW-1:0]         cnt_ext;
    logic [LW-1:0]         lc_ext;
    logic [LW-1:0]         rc_ext;
    logic [AW-1:0]         parent;
    logic [AW-1:0]         last;
    logic [KEY_BITS-1:0]   cur_key;
    logic [KEY_BITS-1:0]   rd_key;
    logic [KEY_BITS-1:0]   best_key;
    logic                  up_stop;
    logic                  lc_gt;
    logic                  rc_gt;

    bmhpq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign cnt_ext  = LW'(r_cnt);
    assign lc_ext   = LW'({r_pos, 1'b1});
    assign rc_ext   = lc_ext + LW'(1);
    assign parent   = (r_pos - AW'(1)) >> 1;
    assign last     = AW'(cnt_ext - LW'(1));
    assign cur_key  = r_cur[EW-1:DATA_BITS];
    assign rd_key   = ram_rdata[EW-1:DATA_BITS];
    assign best_key = r_take ? r_child[EW-1:DATA_BITS] : cur_key;

    // The key compares: each sift-up step asks one key question, each sift-down step two.
    assign up_stop = rd_key >= cur_key;
    assign lc_gt   = rd_key > cur_key;
    assign rc_gt   = r_rc_ok && (rd_key > best_key);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = r_cur;
        ram_raddr = '0;
        case (r_state)
            S_UP: begin
                if (r_pos == '0) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = parent;
                end
            end
            S_UP_CMP: begin
                ram_we = 1'b1;
                if (!up_stop) begin
                    ram_wdata = ram_rdata;
                end
            end
            S_TOP_WAIT: begin
                ram_raddr = last;
            end
            S_DN: begin
                if (lc_ext >= cnt_ext) begin
                    ram_we = 1'b1;
                end else begin
                    ram_raddr = lc_ext[AW-1:0];
                end
            end
            S_DN_L: begin
                ram_raddr = rc_ext[AW-1:0];
            end
            S_DN_R: begin
                ram_we = 1'b1;
                if (rc_gt) begin
                    ram_wdata = ram_rdata;
                end else if (r_take) begin
                    ram_wdata = r_child;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind   <= i_in_word.kind;
                        r_top    <= '0;
                        r_status <= ST_OK;
                        r_cur    <= {i_in_word.key[KEY_BITS-1:0],
                                     i_in_word.payload[DATA_BITS-1:0]};
                        r_pos    <= cnt_ext[AW-1:0];
                        case (i_in_word.kind)
                            KIND_INSERT: begin
                                if (r_cnt >= i_limit) begin
                                    r_status <= ST_OVERFLOW;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_cnt   <= r_cnt + CNT_W'(1);
                                    r_state <= S_UP;
                                end
                            end
                            KIND_EXTRACT, KIND_PEEK: begin
                                if (r_cnt == '0) begin
                                    r_status <= ST_UNDERFLOW;
                                    r_state  <= S_DONE;
                                end else begin
                                    // The root read is issued in this cycle.
                                    r_state <= S_TOP_WAIT;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_UP: begin
                    r_npos  <= parent;
                    r_state <= (r_pos == '0) ? S_DONE : S_UP_CMP;
                end
                S_UP_CMP: begin
                    if (up_stop) begin
                        r_state <= S_DONE;
                    end else begin
                        r_pos   <= r_npos;
                        r_state <= S_UP;
                    end
                end
                S_TOP_WAIT: begin
                    r_top <= ram_rdata;
                    r_pos <= '0;
                    if (r_kind == KIND_PEEK) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= r_cnt - CNT_W'(1);
                        r_state <= S_LAST_WAIT;
                    end
                end
                S_LAST_WAIT: begin
                    // The last entry becomes the hole's occupant at the root.
                    r_cur   <= ram_rdata;
                    r_state <= (r_cnt == '0) ? S_DONE : S_DN;
                end
                S_DN: begin
                    r_npos  <= lc_ext[AW-1:0];
                    r_rc_ok <= rc_ext < cnt_ext;
                    r_state <= (lc_ext >= cnt_ext) ? S_DONE : S_DN_L;
                end
                S_DN_L: begin
                    r_child <= ram_rdata;
                    r_take  <= lc_gt;
                    r_state <= S_DN_R;
                end
                S_DN_R: begin
                    if (rc_gt) begin
                        r_pos   <= r_npos + AW'(1);
                        r_state <= S_DN;
                    end else if (r_take) begin
                        r_pos   <= r_npos;
                        r_state <= S_DN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.top_key     <= FIELD_W'(r_top[EW-1:DATA_BITS]);
                        r_out.top_payload <= FIELD_W'(r_top[DATA_BITS-1:0]);
                        r_out.status      <= r_status;
                        r_out.count       <= r_cnt;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && out_free |=> r_out_valid)
        else $error("finished result was not loaded into the output register");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in_word.kind == KIND_INSERT) && (r_cnt < i_limit)
        |=> r_cnt == $past(r_cnt) + CNT_W'(1))
        else $error("accepted insert did not raise the entry count");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status == ST_UNDERFLOW) |-> r_out.count == '0)
        else $error("underflow reported with entries held");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> LW'(ram_waddr) < cnt_ext)
        else $error("heap write outside the held entries");
`endif

endmodule

@@ hw/rtl/binary_max_heap_priority_queue.sv @@
// Top level of the binary max-heap priority queue: APB limit register and sequencer.
// Depends on bmhpq_pkg and bmhpq_ctrl.
//
//  channel  | direction | handshake                | word
//  ---------+-----------+--------------------------+----------------------------
//  request  | in        | i_in_valid / o_in_stall   | kind, key, payload
//  result   | out       | o_out_valid / i_out_stall | top_key, top_payload, status, count
//  config   | in        | psel, penable, pwrite     | capacity_limit at byte address 0
//
// A request that overflows, underflows or is unused goes straight to the result, a peek
// reads the root, an insert climbs the heap and an extract reads the root and the last
// entry and then descends: an insert level costs one heap RAM read and one compare, an
// extract level two reads, one for each child, and a compare after each.
// Reset clears the entry count and sets the limit to 256; the heap RAM is not cleared.
// While the output register is full and stalled a finished result waits in place.
module binary_max_heap_priority_queue #(
    parameter int CAPACITY  = bmhpq_pkg::DEF_CAPACITY,
    parameter int KEY_BITS  = bmhpq_pkg::DEF_KEY_BITS,
    parameter int DATA_BITS = bmhpq_pkg::DEF_DATA_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bmhpq_pkg::t_in_word           i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bmhpq_pkg::t_out_word          o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmhpq_pkg::PADDR_W-1:0] paddr,
    input  logic [bmhpq_pkg::PDATA_W-1:0] pwdata,
    output logic [bmhpq_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import bmhpq_pkg::*;

    logic [CNT_W-1:0]     r_limit;
    logic [CNT_W-1:0]     eff_limit;
    logic [REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && (reg_idx == REG_CAPACITY_LIMIT)) begin
            r_limit <= pwdata[CNT_W-1:0];
        end
    end

    // The limit saturates at the heap depth.
    assign eff_limit = (32'(r_limit) > CAPACITY) ? CNT_W'(CAPACITY) : r_limit;
    assign prdata    = (reg_idx == REG_CAPACITY_LIMIT) ? PDATA_W'(r_limit) : '0;
    assign pready    = 1'b1;

    bmhpq_ctrl #(
        .CAPACITY  (CAPACITY),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_limit     (eff_limit)
    );

endmodule
